// ===== rtl/core/matchpair_deque_table_defines.svh =====
// Assertion helpers used by the deque table top level.
`ifndef MATCHPAIR_DEQUE_TABLE_DEFINES_SVH
`define MATCHPAIR_DEQUE_TABLE_DEFINES_SVH

// Same-cycle implication.
`define MPDT_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mpdt check failed");

// Next-cycle implication.
`define MPDT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mpdt check failed");

`endif

// ===== rtl/core/mpdt_pkg.sv =====
package mpdt_pkg;

	localparam int NODES = 64;
	localparam int AW    = $clog2(NODES);
	localparam int PW    = $clog2(NODES + 1);

	localparam logic [PW-1:0] NONE_SLOT = PW'(NODES);

	localparam logic [3:0] FN_PUSH_HEAD  = 4'd0;
	localparam logic [3:0] FN_PUSH_TAIL  = 4'd1;
	localparam logic [3:0] FN_POP_HEAD   = 4'd2;
	localparam logic [3:0] FN_POP_TAIL   = 4'd3;
	localparam logic [3:0] FN_REMOVE     = 4'd4;
	localparam logic [3:0] FN_UPDATE     = 4'd5;
	localparam logic [3:0] FN_UNLINK     = 4'd6;
	localparam logic [3:0] FN_START_HEAD = 4'd7;
	localparam logic [3:0] FN_START_TAIL = 4'd8;
	localparam logic [3:0] FN_NEXT       = 4'd9;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_EMPTY     = 3'd1;
	localparam logic [2:0] ST_FULL      = 3'd2;
	localparam logic [2:0] ST_BAD_SLOT  = 3'd3;
	localparam logic [2:0] ST_OVER_DEC  = 3'd4;
	localparam logic [2:0] ST_NO_CURSOR = 3'd5;

	localparam logic DIR_FWD = 1'b0;
	localparam logic DIR_BWD = 1'b1;

	typedef struct packed {
		logic [3:0]  func;
		logic        use_cursor;
		logic [5:0]  slot;
		logic [31:0] new_index;
		logic [15:0] new_tasks;
		logic        new_unlinked;
		logic [15:0] decrement;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [6:0]  out_slot;
		logic [31:0] out_index;
		logic [15:0] out_tasks;
		logic        out_unlinked;
		logic        removed;
		logic        is_empty;
		logic        has_next;
		logic        has_prev;
		logic [6:0]  head_slot;
		logic [6:0]  tail_slot;
	} rsp_t;

	typedef struct packed {
		logic [31:0] index;
		logic [15:0] tasks;
		logic        unl;
	} pay_t;

	typedef struct packed {
		logic accept;
		logic look;
		logic exec;
		logic exec2;
		logic flag;
		logic load;
	} ctl_cmd_t;

	typedef struct packed {
		logic skip;
		logic out_busy;
	} ctl_sts_t;

endpackage

// ===== rtl/core/mpdt_ctrl.sv =====
module mpdt_ctrl
	import mpdt_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  ctl_sts_t sts,
	output ctl_cmd_t cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_LOOK  = 3'd1;
	localparam logic [2:0] S_EXEC  = 3'd2;
	localparam logic [2:0] S_EXEC2 = 3'd3;
	localparam logic [2:0] S_FLAG  = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign req_stall = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_LOOK;
				end
			end
			S_LOOK: begin
				cmd.look = 1'b1;
				state_d  = sts.skip ? S_FLAG : S_EXEC;
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = S_EXEC2;
			end
			S_EXEC2: begin
				cmd.exec2 = 1'b1;
				state_d   = S_FLAG;
			end
			S_FLAG: begin
				cmd.flag = 1'b1;
				state_d  = S_DONE;
			end
			S_DONE: begin
				// hold until the output register frees up
				if (!sts.out_busy) begin
					cmd.load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/core/mpdt_datapath.sv =====
module mpdt_datapath
	import mpdt_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  ctl_cmd_t cmd,
	output ctl_sts_t sts,
	input  req_t     req,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output rsp_t     rsp
);

	req_t          req_q;
	logic [PW-1:0] first_q, last_q, free_q, cur_q;
	logic          back_q;
	logic [NODES-1:0] valid_q;
	logic [NODES-1:0] nxt_wr_q;

	logic [PW-1:0] tgt_q;
	logic [2:0]    stat_q;
	logic          from_flag_q;
	logic          removed_q;
	logic [PW-1:0] ro_slot_q;
	pay_t          ro_pay_q;
	logic          n2_en_q, p2_en_q;
	logic [PW-1:0] n2_a_q, n2_d_q, p2_a_q, p2_d_q;

	logic [PW-1:0] nxt_mem [NODES];
	logic [PW-1:0] prv_mem [NODES];
	pay_t          pay_mem [NODES];
	logic [PW-1:0] nxt_rd_q, prv_rd_q;
	pay_t          pay_rd_q;

	logic          rsp_valid_q;
	rsp_t          rsp_q;

	function automatic logic is_live(input logic [PW-1:0] s, input logic [NODES-1:0] v);
		return (s < NONE_SLOT) && v[s[AW-1:0]];
	endfunction

	logic empty;
	assign empty = (first_q == NONE_SLOT);

	// lookup: pick the target entry and catch errors that need no memory read
	logic [PW-1:0] lk_s, lk_cur;
	logic [2:0]    lk_stat;
	logic          lk_skip, lk_from, lk_back;

	always_comb begin
		lk_s    = NONE_SLOT;
		lk_stat = ST_OK;
		lk_skip = 1'b0;
		lk_from = 1'b0;
		lk_cur  = cur_q;
		lk_back = back_q;
		unique case (req_q.func)
			FN_PUSH_HEAD, FN_PUSH_TAIL: begin
				if (free_q == NONE_SLOT) begin
					lk_stat = ST_FULL;
					lk_skip = 1'b1;
				end else begin
					lk_s = free_q;
				end
			end
			FN_POP_HEAD, FN_POP_TAIL, FN_REMOVE: begin
				if (req_q.func == FN_POP_HEAD) lk_s = first_q;
				else if (req_q.func == FN_POP_TAIL) lk_s = last_q;
				else lk_s = {1'b0, req_q.slot};
				if (empty) begin
					lk_stat = ST_EMPTY;
					lk_skip = 1'b1;
				end else if (!is_live(lk_s, valid_q)) begin
					lk_stat = ST_BAD_SLOT;
					lk_skip = 1'b1;
				end
			end
			FN_UPDATE, FN_UNLINK: begin
				lk_s = req_q.use_cursor ? cur_q : {1'b0, req_q.slot};
				if (empty) begin
					lk_stat = ST_EMPTY;
					lk_skip = 1'b1;
				end else if (!is_live(lk_s, valid_q)) begin
					lk_stat = req_q.use_cursor ? ST_NO_CURSOR : ST_BAD_SLOT;
					lk_skip = 1'b1;
				end
			end
			FN_START_HEAD, FN_START_TAIL: begin
				lk_cur  = NONE_SLOT;
				lk_back = (req_q.func == FN_START_TAIL) ? DIR_BWD : DIR_FWD;
				lk_skip = 1'b1;
			end
			FN_NEXT: begin
				if (empty) begin
					lk_stat = ST_EMPTY;
					lk_skip = 1'b1;
				end else if (cur_q != NONE_SLOT) begin
					lk_s = cur_q;
				end else begin
					lk_cur  = back_q ? last_q : first_q;
					lk_skip = 1'b1;
					lk_from = 1'b1;
				end
			end
			default: lk_skip = 1'b1;
		endcase
	end

	assign sts.skip     = lk_skip;
	assign sts.out_busy = rsp_valid_q && rsp_stall;

	// execute: entry data is back from memory
	logic          n1_en, p1_en, y_en, n2_en, p2_en;
	logic [PW-1:0] n1_a, n1_d, p1_a, p1_d, n2_a, n2_d, p2_a, p2_d;
	pay_t          y_d, mod;
	logic [PW-1:0] ex_first, ex_last, ex_free, ex_cur, ex_oslot;
	logic [2:0]    ex_stat;
	logic          ex_from, ex_removed, ex_detach, vset, take;
	pay_t          ex_pay;

	always_comb begin
		n1_en = 1'b0; n1_a = tgt_q; n1_d = NONE_SLOT;
		p1_en = 1'b0; p1_a = tgt_q; p1_d = NONE_SLOT;
		n2_en = 1'b0; n2_a = tgt_q; n2_d = NONE_SLOT;
		p2_en = 1'b0; p2_a = tgt_q; p2_d = NONE_SLOT;
		y_en  = 1'b0;
		y_d   = '{index: req_q.new_index, tasks: req_q.new_tasks, unl: req_q.new_unlinked};
		mod   = pay_rd_q;
		take  = 1'b0;
		ex_first   = first_q;
		ex_last    = last_q;
		ex_free    = free_q;
		ex_cur     = cur_q;
		ex_oslot   = NONE_SLOT;
		ex_stat    = stat_q;
		ex_from    = from_flag_q;
		ex_removed = 1'b0;
		ex_detach  = 1'b0;
		ex_pay     = '0;
		vset       = 1'b0;
		unique case (req_q.func)
			FN_PUSH_HEAD, FN_PUSH_TAIL: begin
				ex_free  = nxt_rd_q;
				y_en     = 1'b1;
				vset     = 1'b1;
				ex_oslot = tgt_q;
				n1_en    = 1'b1;
				p1_en    = 1'b1;
				if (empty) begin
					ex_first = tgt_q;
					ex_last  = tgt_q;
				end else if (req_q.func == FN_PUSH_HEAD) begin
					n1_d     = first_q;
					p2_en    = 1'b1;
					p2_a     = first_q;
					p2_d     = tgt_q;
					ex_first = tgt_q;
				end else begin
					p1_d    = last_q;
					n2_en   = 1'b1;
					n2_a    = last_q;
					n2_d    = tgt_q;
					ex_last = tgt_q;
				end
			end
			FN_POP_HEAD, FN_POP_TAIL, FN_REMOVE: begin
				ex_oslot  = tgt_q;
				ex_pay    = pay_rd_q;
				ex_detach = 1'b1;
				if (cur_q == tgt_q) ex_cur = NONE_SLOT;
			end
			FN_UPDATE, FN_UNLINK: begin
				take = (req_q.func == FN_UPDATE) ? pay_rd_q.unl : (pay_rd_q.tasks == '0);
				if (req_q.func == FN_UPDATE && !take && req_q.decrement > pay_rd_q.tasks) begin
					ex_stat = ST_OVER_DEC;
				end else begin
					ex_oslot = tgt_q;
					if (take) begin
						ex_pay     = pay_rd_q;
						ex_detach  = 1'b1;
						ex_removed = 1'b1;
						// cursor steps back before its entry goes away
						if (req_q.use_cursor) ex_cur = back_q ? nxt_rd_q : prv_rd_q;
						else if (cur_q == tgt_q) ex_cur = NONE_SLOT;
					end else begin
						if (req_q.func == FN_UPDATE) mod.tasks = pay_rd_q.tasks - req_q.decrement;
						else mod.unl = 1'b1;
						y_en   = 1'b1;
						y_d    = mod;
						ex_pay = mod;
					end
				end
			end
			FN_NEXT: begin
				if ((back_q ? prv_rd_q : nxt_rd_q) == NONE_SLOT) begin
					ex_stat = ST_NO_CURSOR;
				end else begin
					ex_cur  = back_q ? prv_rd_q : nxt_rd_q;
					ex_from = 1'b1;
				end
			end
			default: ;
		endcase
		if (ex_detach) begin
			if (nxt_rd_q == NONE_SLOT) begin
				ex_last = prv_rd_q;
			end else begin
				p1_en = 1'b1;
				p1_a  = nxt_rd_q;
				p1_d  = prv_rd_q;
			end
			if (prv_rd_q == NONE_SLOT) begin
				ex_first = nxt_rd_q;
			end else begin
				n1_en = 1'b1;
				n1_a  = prv_rd_q;
				n1_d  = nxt_rd_q;
			end
			n2_en   = 1'b1;
			n2_a    = tgt_q;
			n2_d    = free_q;
			p2_en   = 1'b1;
			p2_a    = tgt_q;
			p2_d    = NONE_SLOT;
			ex_free = tgt_q;
		end
	end

	// memory ports
	logic          nw_en, pw_en, yw_en, rd_en;
	logic [PW-1:0] nw_a, nw_d, pw_a, pw_d;
	logic [AW-1:0] ra;

	assign nw_en = cmd.exec ? n1_en : (cmd.exec2 && n2_en_q);
	assign nw_a  = cmd.exec ? n1_a : n2_a_q;
	assign nw_d  = cmd.exec ? n1_d : n2_d_q;
	assign pw_en = cmd.exec ? p1_en : (cmd.exec2 && p2_en_q);
	assign pw_a  = cmd.exec ? p1_a : p2_a_q;
	assign pw_d  = cmd.exec ? p1_d : p2_d_q;
	assign yw_en = cmd.exec && y_en;
	assign rd_en = cmd.look || cmd.flag;
	assign ra    = cmd.flag ? cur_q[AW-1:0] : lk_s[AW-1:0];

	always_ff @(posedge clk) begin
		if (nw_en) nxt_mem[nw_a[AW-1:0]] <= nw_d;
		if (pw_en) prv_mem[pw_a[AW-1:0]] <= pw_d;
		if (yw_en) pay_mem[tgt_q[AW-1:0]] <= y_d;
		if (rd_en) begin
			// unwritten next entries read as the initial free chain
			nxt_rd_q <= nxt_wr_q[ra] ? nxt_mem[ra] : ({1'b0, ra} + PW'(1));
			prv_rd_q <= prv_mem[ra];
			pay_rd_q <= pay_mem[ra];
		end
	end

	// architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q     <= NONE_SLOT;
			last_q      <= NONE_SLOT;
			free_q      <= '0;
			cur_q       <= NONE_SLOT;
			back_q      <= DIR_FWD;
			valid_q     <= '0;
			nxt_wr_q    <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.look) begin
				cur_q  <= lk_cur;
				back_q <= lk_back;
			end
			if (cmd.exec) begin
				first_q <= ex_first;
				last_q  <= ex_last;
				free_q  <= ex_free;
				cur_q   <= ex_cur;
				if (vset) valid_q[tgt_q[AW-1:0]] <= 1'b1;
				if (ex_detach) valid_q[tgt_q[AW-1:0]] <= 1'b0;
			end
			if (nw_en) nxt_wr_q[nw_a[AW-1:0]] <= 1'b1;
			if (cmd.load) rsp_valid_q <= 1'b1;
			else if (!rsp_stall) rsp_valid_q <= 1'b0;
		end
	end

	// per-request working registers
	logic hn, hp;

	assign hn = empty ? 1'b0 : ((cur_q != NONE_SLOT) ? (nxt_rd_q != NONE_SLOT) : 1'b1);
	assign hp = empty ? 1'b0 : ((cur_q != NONE_SLOT) ? (prv_rd_q != NONE_SLOT) : 1'b1);

	always_ff @(posedge clk) begin
		if (cmd.accept) req_q <= req;
		if (cmd.look) begin
			tgt_q       <= lk_s;
			stat_q      <= lk_stat;
			from_flag_q <= lk_from;
			removed_q   <= 1'b0;
			ro_slot_q   <= NONE_SLOT;
			ro_pay_q    <= '0;
		end
		if (cmd.exec) begin
			stat_q      <= ex_stat;
			from_flag_q <= ex_from;
			removed_q   <= ex_removed;
			ro_slot_q   <= ex_oslot;
			ro_pay_q    <= ex_pay;
			n2_en_q     <= n2_en;
			n2_a_q      <= n2_a;
			n2_d_q      <= n2_d;
			p2_en_q     <= p2_en;
			p2_a_q      <= p2_a;
			p2_d_q      <= p2_d;
		end
		if (cmd.load) begin
			rsp_q.status       <= stat_q;
			rsp_q.out_slot     <= 7'(from_flag_q ? cur_q : ro_slot_q);
			rsp_q.out_index    <= from_flag_q ? pay_rd_q.index : ro_pay_q.index;
			rsp_q.out_tasks    <= from_flag_q ? pay_rd_q.tasks : ro_pay_q.tasks;
			rsp_q.out_unlinked <= from_flag_q ? pay_rd_q.unl : ro_pay_q.unl;
			rsp_q.removed      <= removed_q;
			rsp_q.is_empty     <= empty;
			rsp_q.has_next     <= hn;
			rsp_q.has_prev     <= hp;
			rsp_q.head_slot    <= 7'(first_q);
			rsp_q.tail_slot    <= 7'(last_q);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== rtl/core/matchpair_deque_table.sv =====
// Sequence: push, pop, remove, update_tasks, unlink and a cursor step read the entry,
// write links in two steps and read the cursor links before the result is loaded;
// start, unused codes, next with no cursor and errors caught at lookup (empty, full,
// bad slot, missing cursor entry) skip the link writes and go on to the cursor read.
// A new request is accepted only after the result is loaded, which waits on rsp_stall.
// Reset (arst_n low): list empty, free list 0..63 in order, cursor none.
`include "matchpair_deque_table_defines.svh"

module matchpair_deque_table
	import mpdt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	mpdt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	mpdt_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	`MPDT_ASSERT_NEXT(a_busy_after_req, req_valid && !req_stall, req_stall)
	`MPDT_ASSERT_SAME(a_ends_agree, rsp_valid, (rsp.head_slot == NONE_SLOT) == (rsp.tail_slot == NONE_SLOT))
	`MPDT_ASSERT_SAME(a_empty_flag, rsp_valid, rsp.is_empty == (rsp.head_slot == NONE_SLOT))

endmodule
